>>> src/wildcard_byte_pattern_search_defines.svh
// ----------------------------------------------------------------------------
// Wildcard byte pattern search: assertion macros
// Clocked assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS
`define WBPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wbps assertion failed");
`define WBPS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("wbps forbidden condition");
`else
`define WBPS_ASSERT(lbl, clk, rst_n, prop)
`define WBPS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

>>> src/wbps_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard byte pattern search package
// Request and result types, configuration view, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

  localparam int unsigned SlotCount  = 16;
  localparam int unsigned MaxPattern = 16;
  localparam int unsigned OffsetBits = 32;
  localparam int unsigned LenBits    = 5;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgBits    = 64;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_WILDCARD     = 3'd2,
    REG_LENGTH       = 3'd3,
    REG_BASE         = 3'd4
  } wbps_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } wbps_req_t;

  typedef struct packed {
    logic        found;
    logic [63:0] match_address;
  } wbps_res_t;

  typedef struct packed {
    logic [127:0]          pattern;
    logic [SlotCount-1:0]  wildcard_mask;
    logic [LenBits-1:0]    pattern_length;
  } wbps_cfg_t;

  typedef struct packed {
    logic               hit;
    logic [LenBits-1:0] len;
  } wbps_hit_t;

  typedef logic [SlotCount-1:0][7:0] wbps_window_t;

endpackage

`default_nettype wire

>>> src/wbps_match.sv
// ----------------------------------------------------------------------------
// Wildcard byte pattern search: window compare
// Masked parallel compare of the byte window against the pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_match (
  input  wire wbps_pkg::wbps_cfg_t       cfg_i,
  input  wire wbps_pkg::wbps_window_t    window_i,
  input  wire [wbps_pkg::OffsetBits-1:0] offset_i,
  output wbps_pkg::wbps_hit_t            hit_o
);
  import wbps_pkg::*;

  logic [LenBits-1:0] len;
  logic [LenBits-1:0] idx;
  logic               all_ok;

  always_comb begin
    len = cfg_i.pattern_length;
    if (len == '0) begin
      len = LenBits'(1);
    end else if (len > LenBits'(MaxPattern)) begin
      len = LenBits'(MaxPattern);
    end
  end

  always_comb begin
    all_ok = 1'b1;
    idx    = '0;
    for (int i = 0; i < SlotCount; i++) begin
      idx = len - LenBits'(1) - LenBits'(i);
      if (LenBits'(i) < len && !cfg_i.wildcard_mask[i] &&
          window_i[idx[3:0]] != cfg_i.pattern[8*i +: 8]) begin
        all_ok = 1'b0;
      end
    end
  end

  assign hit_o.len = len;
  assign hit_o.hit = all_ok && (offset_i >= OffsetBits'(len));

endmodule

`default_nettype wire

>>> src/wildcard_byte_pattern_search.sv
// ----------------------------------------------------------------------------
// Wildcard byte pattern search
// Finds the first match of a masked byte pattern in a streamed region.
// ----------------------------------------------------------------------------
// Takes one byte per cycle. Each request is compared in the cycle it is
// accepted, with the window shifted by the new byte, and any result is
// registered in a single output register. Requests keep flowing as long as
// that register is empty or being drained; a held result stalls the input.
// A region yields one result: found=1 with the match address on the first
// match, or found=0 on the last byte if nothing matched. Configuration takes
// effect with the next accepted byte.
`default_nettype none

`include "wildcard_byte_pattern_search_defines.svh"

module wildcard_byte_pattern_search (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire [wbps_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  wire [wbps_pkg::CfgBits-1:0]        cfg_data_i,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire wbps_pkg::wbps_req_t           in_req_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output wbps_pkg::wbps_res_t                out_res_o
);
  import wbps_pkg::*;

  wbps_cfg_t             cfg_q;
  logic [63:0]           base_q;
  wbps_window_t          window_q, window_d;
  logic [OffsetBits-1:0] offset_q, offset_d;
  logic                  done_q, done_d;
  logic                  out_valid_q, out_valid_d;
  wbps_res_t             res_q, res_d;
  wbps_hit_t             hit;
  logic                  in_acc, out_acc, emit;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern        <= '0;
      cfg_q.wildcard_mask  <= '0;
      cfg_q.pattern_length <= LenBits'(1);
      base_q               <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PATTERN_LOW:  cfg_q.pattern[63:0]   <= cfg_data_i;
        REG_PATTERN_HIGH: cfg_q.pattern[127:64] <= cfg_data_i;
        REG_WILDCARD:     cfg_q.wildcard_mask   <= cfg_data_i[SlotCount-1:0];
        REG_LENGTH:       cfg_q.pattern_length  <= cfg_data_i[LenBits-1:0];
        REG_BASE:         base_q                <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    window_d[0] = in_req_i.data_byte;
    for (int k = 1; k < SlotCount; k++) begin
      window_d[k] = window_q[k-1];
    end
    offset_d = (offset_q == '1) ? offset_q : offset_q + OffsetBits'(1);
  end

  wbps_match u_match (
    .cfg_i    (cfg_q),
    .window_i (window_d),
    .offset_i (offset_d),
    .hit_o    (hit)
  );

  always_comb begin
    emit                = 1'b0;
    res_d               = res_q;
    done_d              = done_q;
    out_valid_d         = out_acc ? 1'b0 : out_valid_q;
    if (in_acc && !done_q) begin
      if (hit.hit) begin
        emit                = 1'b1;
        done_d              = 1'b1;
        res_d.found         = 1'b1;
        res_d.match_address = base_q + 64'(offset_d - OffsetBits'(hit.len));
      end else if (in_req_i.last_byte) begin
        emit                = 1'b1;
        res_d.found         = 1'b0;
        res_d.match_address = '0;
      end
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= '0;
      offset_q    <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        if (in_req_i.last_byte) begin
          window_q <= '0;
          offset_q <= '0;
          done_q   <= 1'b0;
        end else if (!done_q) begin
          window_q <= window_d;
          offset_q <= offset_d;
          done_q   <= done_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  `WBPS_ASSERT(a_full_stalls_in, clk_i, rst_ni, (out_valid_q && out_stall_i) |-> in_stall_o)
  `WBPS_ASSERT(a_done_has_bytes, clk_i, rst_ni, done_q |-> (offset_q != '0))
  `WBPS_ASSERT(a_last_clears, clk_i, rst_ni, (in_acc && in_req_i.last_byte) |=> (offset_q == '0 && !done_q))
  `WBPS_ASSERT_NEVER(a_miss_addr_zero, clk_i, rst_ni, out_valid_q && !res_q.found && res_q.match_address != '0)

endmodule

`default_nettype wire
